[hw/rtl/rotf_pkg.sv]
// Shared types and constants for the forward-mapping image rotator.
`default_nettype none

package rotf_pkg;

  // Fixed field widths of the input and result words.
  localparam int unsigned COORD_BITS     = 12;
  localparam int unsigned DIM_BITS       = 13;
  localparam int unsigned TRIG_BITS      = 16;
  localparam int unsigned PIXEL_BITS     = 32;
  localparam int unsigned ADDR_BITS      = 24;
  localparam int unsigned TRIG_FRAC_BITS = 14;
  localparam int unsigned MAX_DIM        = 4096;

  // Configuration port.
  localparam int unsigned APB_ADDR_BITS = 5;
  localparam int unsigned APB_DATA_BITS = 32;

  // Datapath widths derived from the fields.
  localparam int unsigned CENT_BITS = DIM_BITS + 2;          // centered half-pixel coordinate
  localparam int unsigned PROD_BITS = CENT_BITS + TRIG_BITS; // one rotation product
  localparam int unsigned SUM_BITS  = PROD_BITS + 2;         // rotated position
  localparam int unsigned POS_BITS  = SUM_BITS - TRIG_FRAC_BITS - 1; // integer pixel part

  localparam logic [DIM_BITS-1:0]  DIM_RESET = DIM_BITS'(MAX_DIM);
  localparam logic [TRIG_BITS-1:0] COS_RESET = TRIG_BITS'(1 << TRIG_FRAC_BITS);
  localparam logic [TRIG_BITS-1:0] SIN_RESET = '0;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_COS        = 3'd4,
    REG_SIN        = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic        [DIM_BITS-1:0]  src_width;
    logic        [DIM_BITS-1:0]  src_height;
    logic        [DIM_BITS-1:0]  dst_width;
    logic        [DIM_BITS-1:0]  dst_height;
    logic signed [TRIG_BITS-1:0] cos_q14;
    logic signed [TRIG_BITS-1:0] sin_q14;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_col;
    logic [COORD_BITS-1:0] src_row;
    logic [PIXEL_BITS-1:0] pixel_value;
  } rotf_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] dest_col;
    logic [COORD_BITS-1:0] dest_row;
    logic [ADDR_BITS-1:0]  dest_address;
    logic [PIXEL_BITS-1:0] pixel_out;
  } rotf_out_t;

endpackage

`default_nettype wire

[hw/rtl/rotf_regs.sv]
// APB register file holding image sizes and rotation coefficients.
`default_nettype none

module rotf_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rotf_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [rotf_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic      [rotf_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                      pready,
  output rotf_pkg::cfg_t                            cfg
);
  import rotf_pkg::*;

  reg_index_t idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width  <= DIM_RESET;
      cfg.src_height <= DIM_RESET;
      cfg.dst_width  <= DIM_RESET;
      cfg.dst_height <= DIM_RESET;
      cfg.cos_q14    <= COS_RESET;
      cfg.sin_q14    <= SIN_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SRC_WIDTH:  cfg.src_width  <= pwdata[DIM_BITS-1:0];
        REG_SRC_HEIGHT: cfg.src_height <= pwdata[DIM_BITS-1:0];
        REG_DST_WIDTH:  cfg.dst_width  <= pwdata[DIM_BITS-1:0];
        REG_DST_HEIGHT: cfg.dst_height <= pwdata[DIM_BITS-1:0];
        REG_COS:        cfg.cos_q14    <= pwdata[TRIG_BITS-1:0];
        REG_SIN:        cfg.sin_q14    <= pwdata[TRIG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_WIDTH:  prdata = APB_DATA_BITS'(cfg.src_width);
      REG_SRC_HEIGHT: prdata = APB_DATA_BITS'(cfg.src_height);
      REG_DST_WIDTH:  prdata = APB_DATA_BITS'(cfg.dst_width);
      REG_DST_HEIGHT: prdata = APB_DATA_BITS'(cfg.dst_height);
      REG_COS:        prdata = APB_DATA_BITS'(unsigned'(cfg.cos_q14));
      REG_SIN:        prdata = APB_DATA_BITS'(unsigned'(cfg.sin_q14));
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/rotf_core.sv]
// Four-stage rotation pipeline: input, products, bounds check, address.
`default_nettype none

module rotf_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rotf_pkg::cfg_t      cfg,
  input  wire logic                src_valid,
  output logic                     src_stall,
  input  wire rotf_pkg::rotf_in_t  src_word,
  output logic                     dest_valid,
  input  wire logic                dest_stall,
  output rotf_pkg::rotf_out_t      dest_word
);
  import rotf_pkg::*;

  // Stage 1: input register.
  logic                  s1_valid;
  rotf_in_t              s1;
  // Stage 2: rotation products.
  logic                  s2_valid;
  logic signed [PROD_BITS-1:0] s2_xc, s2_ys, s2_xs, s2_yc;
  logic [PIXEL_BITS-1:0] s2_pix;
  // Stage 3: destination position, dropped when outside.
  logic                  s3_valid;
  logic [COORD_BITS-1:0] s3_col, s3_row;
  logic [PIXEL_BITS-1:0] s3_pix;

  logic s1_load, s2_load, s3_load, out_load;

  // Each stage takes a new word when it is empty or its word moves on.
  assign out_load  = !dest_valid || !dest_stall;
  assign s3_load   = !s3_valid || out_load;
  assign s2_load   = !s2_valid || s3_load;
  assign s1_load   = !s1_valid || s2_load;
  assign src_stall = !s1_load;

  // Centering in half pixels.
  logic signed [CENT_BITS-1:0] cx, cy;
  assign cx = signed'({2'b00, s1.src_col, 1'b0}) - signed'(CENT_BITS'(cfg.src_width));
  assign cy = signed'({2'b00, s1.src_row, 1'b0}) - signed'(CENT_BITS'(cfg.src_height));

  // Position sums and bounds.
  logic signed [SUM_BITS-1:0] x_pos, y_pos, x_off, y_off;
  logic [POS_BITS-1:0]        dc, dr;
  logic                       in_bounds;

  assign x_off = signed'(SUM_BITS'(cfg.dst_width) << TRIG_FRAC_BITS);
  assign y_off = signed'(SUM_BITS'(cfg.dst_height) << TRIG_FRAC_BITS);
  assign x_pos = SUM_BITS'(s2_xc) - SUM_BITS'(s2_ys) + x_off;
  assign y_pos = SUM_BITS'(s2_xs) + SUM_BITS'(s2_yc) + y_off;
  assign dc    = x_pos[SUM_BITS-1 -: POS_BITS];
  assign dr    = y_pos[SUM_BITS-1 -: POS_BITS];

  // A negative position has its top bit set, so it also fails the compare
  // against MAX_DIM; the sign test is kept for clarity.
  assign in_bounds = !x_pos[SUM_BITS-1] && !y_pos[SUM_BITS-1]
               && (dc < POS_BITS'(cfg.dst_width)) && (dr < POS_BITS'(cfg.dst_height))
               && (dc < POS_BITS'(MAX_DIM)) && (dr < POS_BITS'(MAX_DIM));

  logic [2*DIM_BITS-1:0] addr_full;
  assign addr_full = (2*DIM_BITS)'(s3_row) * (2*DIM_BITS)'(cfg.dst_width)
                   + (2*DIM_BITS)'(s3_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      dest_valid <= 1'b0;
    end else begin
      if (s1_load)  s1_valid   <= src_valid;
      if (s2_load)  s2_valid   <= s1_valid;
      if (s3_load)  s3_valid   <= s2_valid && in_bounds;
      if (out_load) dest_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= src_word;
    end
    if (s2_load) begin
      s2_xc  <= PROD_BITS'(cx) * PROD_BITS'(cfg.cos_q14);
      s2_ys  <= PROD_BITS'(cy) * PROD_BITS'(cfg.sin_q14);
      s2_xs  <= PROD_BITS'(cx) * PROD_BITS'(cfg.sin_q14);
      s2_yc  <= PROD_BITS'(cy) * PROD_BITS'(cfg.cos_q14);
      s2_pix <= s1.pixel_value;
    end
    if (s3_load) begin
      s3_col <= dc[COORD_BITS-1:0];
      s3_row <= dr[COORD_BITS-1:0];
      s3_pix <= s2_pix;
    end
    if (out_load) begin
      dest_word.dest_col     <= s3_col;
      dest_word.dest_row     <= s3_row;
      dest_word.dest_address <= addr_full[ADDR_BITS-1:0];
      dest_word.pixel_out    <= s3_pix;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/image_rotate_forward_map.sv]
// Top level of the forward-mapping image rotator with truncating placement.
//
// Each source word (column, row, pixel) is centered on the source image in
// half pixels, rotated by the programmed Q2.14 cosine and sine, and placed on
// the destination image. A word whose rotated position lands inside the
// destination comes out with its truncated column, row, linear address
// (row * dst_width + column) and the pixel unchanged; any other word is
// dropped. The block takes one word every clock unless the pipeline is full and
// the result word is held. An accepted word sits in the input register, then
// passes the three stages behind it: the four rotation multipliers, the
// position sum and bounds check, and the address multiply-add. Registers must
// be written over APB only while no word is in flight; the block does not check.
`default_nettype none

module image_rotate_forward_map (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rotf_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [rotf_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [rotf_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready,
  input  wire logic                                src_valid,
  output logic                                     src_stall,
  input  wire rotf_pkg::rotf_in_t                  src_word,
  output logic                                     dest_valid,
  input  wire logic                                dest_stall,
  output rotf_pkg::rotf_out_t                      dest_word
);
  import rotf_pkg::*;

  cfg_t cfg;

  rotf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rotf_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_word   (src_word),
    .dest_valid (dest_valid),
    .dest_stall (dest_stall),
    .dest_word  (dest_word)
  );

  // The pipeline only pushes back when every stage is full and the result
  // word is held.
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (dest_valid && dest_stall))
    else $error("input stalled while the result register can move");

  // Every word that comes out lies inside the destination image.
  a_result_inside: assert property (@(posedge clk) disable iff (rst)
    dest_valid |-> ((DIM_BITS'(dest_word.dest_col) < cfg.dst_width)
                 && (DIM_BITS'(dest_word.dest_row) < cfg.dst_height)))
    else $error("result word lies outside the destination image");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the forward-mapping image rotator, with its placement scoreboard.
module tb_top;
  import rotf_pkg::*;

  // Predicts where each source word lands and holds the words still owed by the block.
  class rotation_scoreboard;
    cfg_t        cfg;
    rotf_out_t   placed_q[$];
    int unsigned failures;

    function new();
      cfg.src_width  = DIM_RESET;
      cfg.src_height = DIM_RESET;
      cfg.dst_width  = DIM_RESET;
      cfg.dst_height = DIM_RESET;
      cfg.cos_q14    = COS_RESET;
      cfg.sin_q14    = SIN_RESET;
      failures       = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [APB_DATA_BITS-1:0] value);
      case (idx)
        REG_SRC_WIDTH:  cfg.src_width  = value[DIM_BITS-1:0];
        REG_SRC_HEIGHT: cfg.src_height = value[DIM_BITS-1:0];
        REG_DST_WIDTH:  cfg.dst_width  = value[DIM_BITS-1:0];
        REG_DST_HEIGHT: cfg.dst_height = value[DIM_BITS-1:0];
        REG_COS:        cfg.cos_q14    = value[TRIG_BITS-1:0];
        REG_SIN:        cfg.sin_q14    = value[TRIG_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(rotf_in_t w);
      longint    cx, cy, cs, sn, px, py, col, row;
      rotf_out_t r;
      // Centered coordinates are in half pixels, so the positions carry one extra
      // fraction bit beyond the trig format.
      cx  = 2 * longint'(w.src_col) - longint'(cfg.src_width);
      cy  = 2 * longint'(w.src_row) - longint'(cfg.src_height);
      cs  = longint'($signed(cfg.cos_q14));
      sn  = longint'($signed(cfg.sin_q14));
      px  = cx * cs - cy * sn + (longint'(cfg.dst_width) <<< TRIG_FRAC_BITS);
      py  = cx * sn + cy * cs + (longint'(cfg.dst_height) <<< TRIG_FRAC_BITS);
      if (px < 0 || py < 0) return;
      col = px >>> (TRIG_FRAC_BITS + 1);
      row = py >>> (TRIG_FRAC_BITS + 1);
      if (col >= longint'(cfg.dst_width) || row >= longint'(cfg.dst_height)) return;
      if (col >= longint'(MAX_DIM) || row >= longint'(MAX_DIM)) return;
      r.dest_col     = col[COORD_BITS-1:0];
      r.dest_row     = row[COORD_BITS-1:0];
      r.dest_address = ADDR_BITS'(row * longint'(cfg.dst_width) + col);
      r.pixel_out    = w.pixel_value;
      placed_q.push_back(r);
    endfunction

    function void check_result(rotf_out_t got);
      rotf_out_t exp;
      if (placed_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected word col=%0d row=%0d addr=%0d pix=%h",
                   $realtime, got.dest_col, got.dest_row, got.dest_address, got.pixel_out);
        return;
      end
      exp = placed_q.pop_front();
      if (got.dest_col !== exp.dest_col || got.dest_row !== exp.dest_row ||
          got.dest_address !== exp.dest_address || got.pixel_out !== exp.pixel_out) begin
        failures++;
        if (failures <= 10)
          $display({"%0t: mismatch expected col=%0d row=%0d addr=%0d pix=%h,",
                    " got col=%0d row=%0d addr=%0d pix=%h"},
                   $realtime, exp.dest_col, exp.dest_row, exp.dest_address, exp.pixel_out,
                   got.dest_col, got.dest_row, got.dest_address, got.pixel_out);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     src_valid;
  logic                     src_stall;
  rotf_in_t                 src_word;
  logic                     dest_valid;
  logic                     dest_stall = 1'b0;
  rotf_out_t                dest_word;

  rotation_scoreboard sb;
  int unsigned        src_idle_pct   = 0;
  int unsigned        dest_stall_pct = 0;

  // Common rotation angles: 0, 90, 180, 270, 45, 30, 60 and 135 degrees.
  logic signed [TRIG_BITS-1:0] cos_tab [8] = '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0,
                                               16'sd11585, 16'sd14189, 16'sd8192,
                                               -16'sd11585};
  logic signed [TRIG_BITS-1:0] sin_tab [8] = '{16'sd0, 16'sd16384, 16'sd0, -16'sd16384,
                                               16'sd11585, 16'sd8192, 16'sd14189,
                                               16'sd11585};

  image_rotate_forward_map u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_word   (src_word),
    .dest_valid (dest_valid),
    .dest_stall (dest_stall),
    .dest_word  (dest_word)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    dest_stall <= ($urandom_range(99) < dest_stall_pct);
  end

  // Inputs are noted before results so a word and its own result can never race.
  always @(posedge clk) begin
    if (!rst) begin
      if (src_valid && !src_stall) sb.note_input(src_word);
      if (dest_valid && !dest_stall) sb.check_result(dest_word);
    end
  end

  function automatic cfg_t make_cfg(int sw, int sh, int dw, int dh, int cs, int sn);
    cfg_t c;
    c.src_width  = DIM_BITS'(sw);
    c.src_height = DIM_BITS'(sh);
    c.dst_width  = DIM_BITS'(dw);
    c.dst_height = DIM_BITS'(dh);
    c.cos_q14    = TRIG_BITS'(cs);
    c.sin_q14    = TRIG_BITS'(sn);
    return c;
  endfunction

  function automatic logic [DIM_BITS-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return DIM_BITS'($urandom_range(1, 16));
    if (r == 1) return DIM_BITS'($urandom_range((1 << DIM_BITS) - 1));
    return DIM_BITS'($urandom_range(1, MAX_DIM));
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t        c;
    int unsigned k;
    c.src_width  = pick_dim();
    c.src_height = pick_dim();
    if ($urandom_range(1) == 0) begin
      c.dst_width  = c.src_width;
      c.dst_height = c.src_height;
    end else begin
      c.dst_width  = pick_dim();
      c.dst_height = pick_dim();
    end
    k = $urandom_range(7);
    if ($urandom_range(4) == 0) begin
      c.cos_q14 = TRIG_BITS'($urandom);
      c.sin_q14 = TRIG_BITS'($urandom);
    end else begin
      c.cos_q14 = cos_tab[k];
      c.sin_q14 = sin_tab[k];
    end
    return c;
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord(logic [DIM_BITS-1:0] size);
    // Mostly coordinates inside the source image, the rest anywhere in the field.
    if (size == 0 || size > MAX_DIM || $urandom_range(99) < 15)
      return COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
    return COORD_BITS'($urandom_range(size - 1));
  endfunction

  function automatic rotf_in_t pixel_at(int col, int row, logic [PIXEL_BITS-1:0] pix);
    rotf_in_t w;
    w.src_col     = COORD_BITS'(col);
    w.src_row     = COORD_BITS'(row);
    w.pixel_value = pix;
    return w;
  endfunction

  task automatic send_word(input rotf_in_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_word  <= w;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(input reg_index_t idx, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(int'(idx) * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  // Settings change only once every owed word is out and dropped words have left the pipe.
  task automatic program_block(input cfg_t c);
    src_valid <= 1'b0;
    while (sb.placed_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    apb_write(REG_SRC_WIDTH,  APB_DATA_BITS'(c.src_width));
    apb_write(REG_SRC_HEIGHT, APB_DATA_BITS'(c.src_height));
    apb_write(REG_DST_WIDTH,  APB_DATA_BITS'(c.dst_width));
    apb_write(REG_DST_HEIGHT, APB_DATA_BITS'(c.dst_height));
    apb_write(REG_COS,        APB_DATA_BITS'(c.cos_q14));
    apb_write(REG_SIN,        APB_DATA_BITS'(c.sin_q14));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_corners();
    send_word(pixel_at(0, 0, $urandom));
    send_word(pixel_at(4095, 4095, $urandom));
    send_word(pixel_at(0, 4095, $urandom));
    send_word(pixel_at(4095, 0, $urandom));
  endtask

  initial begin
    cfg_t c;
    sb        = new();
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    src_valid = 1'b0;
    src_word  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings map every source pixel onto itself.
    send_word(pixel_at(0, 0, 32'h0000_0000));
    send_word(pixel_at(4095, 4095, 32'hFFFF_FFFF));
    send_word(pixel_at(4095, 0, 32'hAAAA_AAAA));
    send_word(pixel_at(0, 4095, 32'h5555_5555));
    send_word(pixel_at(2048, 2047, 32'h1234_5678));

    // Quarter turn on the full image.
    program_block(make_cfg(4096, 4096, 4096, 4096, 0, 16384));
    send_corners();
    // An empty destination takes nothing.
    program_block(make_cfg(4096, 4096, 0, 0, 16384, 0));
    send_corners();
    // Destination wider than the coordinate field: far columns cannot be placed.
    program_block(make_cfg(4096, 4096, 8191, 8191, 16384, 0));
    send_corners();
    // Trig values beyond one, and source coordinates far past a one-pixel source.
    program_block(make_cfg(1, 1, 4096, 4096, -32768, 32767));
    send_corners();
    src_valid <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       c = make_cfg(4096, 4096, 4096, 4096, 16384, 0);
        1:       c = make_cfg(1, 1, 1, 1, 16384, 0);
        2:       c = make_cfg(4096, 4096, 4096, 4096, -16384, 0);
        default: c = random_cfg();
      endcase
      program_block(c);
      case (p % 4)
        0: begin
          src_idle_pct   = 0;
          dest_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 80;
          dest_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          dest_stall_pct = 80;
        end
        default: begin
          src_idle_pct   = 15;
          dest_stall_pct = 15;
        end
      endcase
      repeat (128)
        send_word(pixel_at(pick_coord(sb.cfg.src_width), pick_coord(sb.cfg.src_height), $urandom));
      src_valid <= 1'b0;
      @(negedge clk);
    end

    while (sb.placed_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
